FILE: sv/scrolled_window_blitter_unit_macros.svh
// assertion macros for the scrolled window blitter
// used by the top level only; needs a clock and an active-low reset name
`ifndef SCROLLED_WINDOW_BLITTER_UNIT_MACROS_SVH
`define SCROLLED_WINDOW_BLITTER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SWB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SWB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/swb_pkg.sv
// shared types and constants of the scrolled window blitter
// no dependencies
`default_nettype none

package swb_pkg;

    localparam int SCREEN_WORDS = 15;
    localparam int BUFFER_WORDS = 17;

    localparam int WORD_W  = 16;
    localparam int POS_W   = 5;
    localparam int INDEX_W = 4;
    localparam int SHIFT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        CMB_REPLACE = 2'd0,
        CMB_OR      = 2'd1,
        CMB_AND     = 2'd2
    } t_combine;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_X     = 2'd0,
        REG_COMBINE_MODE = 2'd1,
        REG_GRAY_ENABLE  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [4:0] window_x;
        logic [1:0] combine_mode;
        logic       gray_enable;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/swb_cfg.sv
// configuration register file of the scrolled window blitter
// depends on swb_pkg
`default_nettype none

module swb_cfg
    import swb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_x     <= '0;
            r_cfg.combine_mode <= CMB_REPLACE;
            r_cfg.gray_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW_X:     r_cfg.window_x     <= i_cfg_data[4:0];
                REG_COMBINE_MODE: r_cfg.combine_mode <= i_cfg_data[1:0];
                REG_GRAY_ENABLE:  r_cfg.gray_enable  <= i_cfg_data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/swb_plane.sv
// funnel shift and destination merge for one bit plane
// depends on swb_pkg
`default_nettype none

module swb_plane
    import swb_pkg::*;
(
    input  wire logic [WORD_W-1:0]  i_prev,
    input  wire logic [WORD_W-1:0]  i_src,
    input  wire logic [WORD_W-1:0]  i_dest,
    input  wire logic [SHIFT_W-1:0] i_shift,
    input  wire logic [1:0]         i_mode,
    output logic      [WORD_W-1:0]  o_word
);

    logic [2*WORD_W-1:0] pair_shifted;
    logic [WORD_W-1:0]   screen_word;

    // upper half of {prev, src} << s; shift 0 leaves prev as is
    always_comb begin
        pair_shifted = {i_prev, i_src} << i_shift;
        screen_word  = pair_shifted[2*WORD_W-1:WORD_W];
    end

    always_comb begin
        case (t_combine'(i_mode))
            CMB_OR:  o_word = screen_word | i_dest;
            CMB_AND: o_word = screen_word & i_dest;
            default: o_word = screen_word;  // replace, unused code too
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/scrolled_window_blitter_unit.sv
// scrolled window blitter: top level with input stage, row position and result register
// depends on swb_pkg, swb_cfg, swb_plane and the assertion macro header
//
// usage:
//   s_axis carries one source column per request: tdata holds src_light, src_dark,
//   dest_light and dest_dark, tlast marks the last source word of a buffer row.
//   m_axis returns one screen word per request that completes a visible position:
//   tdata holds out_light, out_dark and out_index, tlast flags the final visible word.
//   requests that complete no screen word (the skipped first word, the left edge word,
//   surplus words past the visible row) are consumed without a result.
//   the config port writes window_x, combine_mode and gray_enable; write only when idle.
// timing:
//   one request per cycle sustained while m_axis accepts; a result passes from the input
//   register to the result register, with one funnel and merge between them.
//   s_axis_tready drops only when both the input register and the result register are
//   full and m_axis is stalled; no request is lost or repeated under backpressure.
// reset:
//   synchronous, active low; clears both pipeline stages, the previous source words and
//   the row position, and loads window_x 0, combine_mode replace, gray mode on.
`default_nettype none

module scrolled_window_blitter_unit
    import swb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // source stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] src_light, [31:16] src_dark, [47:32] dest_light, [63:48] dest_dark
    input  wire logic [63:0]           s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] out_light, [31:16] out_dark, [35:32] out_index, [39:36] zero
    output logic      [39:0]           m_axis_tdata,
    output logic                       m_axis_tlast
);

    `include "scrolled_window_blitter_unit_macros.svh"

    t_cfg cfg;

    // input stage
    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_src_light;
    logic [WORD_W-1:0] r_in_src_dark;
    logic [WORD_W-1:0] r_in_dest_light;
    logic [WORD_W-1:0] r_in_dest_dark;
    logic              r_in_last;

    // row state
    logic [WORD_W-1:0] r_prev_light;
    logic [WORD_W-1:0] r_prev_dark;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;

    // result stage
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_light;
    logic [WORD_W-1:0]  r_out_dark;
    logic [INDEX_W-1:0] r_out_index;
    logic               r_out_last;

    logic              out_free;
    logic              advance;
    logic              accept;
    logic              skip;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  k;
    logic              emit;
    logic [WORD_W-1:0] src_dark_eff;
    logic [WORD_W-1:0] word_light;
    logic [WORD_W-1:0] word_dark;

    swb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_src_light  <= s_axis_tdata[15:0];
            r_in_src_dark   <= s_axis_tdata[31:16];
            r_in_dest_light <= s_axis_tdata[47:32];
            r_in_dest_dark  <= s_axis_tdata[63:48];
            r_in_last       <= s_axis_tlast;
        end
    end

    // position decode: screen word k = p - skip - 1
    always_comb begin
        skip      = cfg.window_x[4];
        first_pos = POS_W'(1) + POS_W'(skip);
        k         = r_pos - first_pos;
        emit      = (r_pos != POS_MAX) && (r_pos >= first_pos)
                    && ({1'b0, r_pos} < (POS_W+1)'(BUFFER_WORDS))
                    && ({1'b0, k} < (POS_W+1)'(SCREEN_WORDS));
    end

    always_comb begin
        if (r_in_last) begin
            n_pos = '0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    assign src_dark_eff = cfg.gray_enable ? r_in_src_dark : '0;

    swb_plane u_plane_light (
        .i_prev  (r_prev_light),
        .i_src   (r_in_src_light),
        .i_dest  (r_in_dest_light),
        .i_shift (cfg.window_x[SHIFT_W-1:0]),
        .i_mode  (cfg.combine_mode),
        .o_word  (word_light)
    );

    swb_plane u_plane_dark (
        .i_prev  (r_prev_dark),
        .i_src   (src_dark_eff),
        .i_dest  (r_in_dest_dark),
        .i_shift (cfg.window_x[SHIFT_W-1:0]),
        .i_mode  (cfg.combine_mode),
        .o_word  (word_dark)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_light <= '0;
            r_prev_dark  <= '0;
            r_pos        <= '0;
        end else if (advance) begin
            r_prev_light <= r_in_src_light;
            r_prev_dark  <= src_dark_eff;
            r_pos        <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_light <= word_light;
            r_out_dark  <= cfg.gray_enable ? word_dark : '0;
            r_out_index <= k[INDEX_W-1:0];
            r_out_last  <= (k == POS_W'(SCREEN_WORDS - 1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_index, r_out_dark, r_out_light};
    assign m_axis_tlast  = r_out_last;

    // a stalled input stage only ever waits on a stalled result
    `SWB_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n,
        !s_axis_tready, r_in_valid && r_out_valid && !m_axis_tready,
        "input stalled without result backpressure")

    // the row position restarts after the last word of a row
    `SWB_ASSERT_NEXT(a_row_restart, i_clk, i_rst_n,
        advance && r_in_last, r_pos == '0,
        "row position not cleared after row end")

    // an overlong row holds the position at its ceiling
    `SWB_ASSERT_NEXT(a_pos_saturate, i_clk, i_rst_n,
        advance && !r_in_last && r_pos == POS_MAX, r_pos == POS_MAX,
        "row position wrapped past its ceiling")

endmodule

`default_nettype wire
